// ===== hw/rtl/sorted_priority_queue_assert.svh =====
// assertion macros for the sorted priority queue checker
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// clocked check, off while reset is high
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define SPQ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/spq_pkg.sv =====
// types and constants of the sorted priority queue
`timescale 1ns / 1ps

package spq_pkg;

  localparam int VAL_W        = 32;
  localparam int PRI_W        = 16;
  localparam int COUNT_W      = 5;
  localparam int CAPACITY_DEF = 16;
  localparam int ENTRY_W      = VAL_W + PRI_W;

  typedef enum logic {
    REQ_INSERT  = 1'b0,
    REQ_EXTRACT = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_WR,
    ST_EXT_SH,
    ST_OUT
  } state_t;

  typedef struct packed {
    req_type_t                req_type;
    logic signed [VAL_W-1:0]  item_value;
    logic        [PRI_W-1:0]  item_priority;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  out_value;
    logic        [PRI_W-1:0]  out_priority;
    logic                     out_valid;
    status_t                  status;
    logic        [COUNT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic        [PRI_W-1:0] prio;
  } entry_t;

endpackage

// ===== hw/rtl/spq_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// sorted priority queue top level: sequencer around one entry ram
//
//   channel | ports                      | direction | beat
//   request | req_valid, req_ready, req  | in        | insert or extract
//   result  | rsp_valid, rsp_ready, rsp  | out       | one per request
//
// insert: stored entries of equal or larger priority move up one slot, last first, then the new one is written
// extract: the head entry is returned and every remaining entry is moved down one slot
// full insert or empty extract: no ram access, straight to the result state
// the ram moves the entries, at most one entry read and one written per cycle
// synchronous reset empties the queue at once; the ram is not cleared
// a stalled result holds in its register while the next request is taken
`timescale 1ns / 1ps

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t          state, state_next;
  logic [AW-1:0]   idx, idx_next;
  logic [CW-1:0]   occ, occ_next;
  req_t            req_q, req_q_next;
  rsp_t            res, res_next;
  rsp_t            rsp_next;
  logic            rsp_valid_next;

  logic            ram_wr_en, ram_rd_en;
  logic [AW-1:0]   ram_wr_addr, ram_rd_addr;
  entry_t          ram_wr_data, rd_entry, new_entry;

  logic            is_full, is_empty, ins_shift, more, rsp_free;
  logic [AW-1:0]   idx_up, idx_dn, occ_last;
  logic [CW-1:0]   idx_inc;
  logic [CW+COUNT_W-1:0] occ_wide;

  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (rd_entry)
  );

  assign is_full   = (occ == CW'(CAPACITY));
  assign is_empty  = (occ == '0);
  assign ins_shift = (rd_entry.prio >= req_q.item_priority);
  assign idx_up    = idx + AW'(1);
  assign idx_dn    = idx - AW'(1);
  assign idx_inc   = CW'(idx) + CW'(1);
  assign more      = (idx_inc < occ);
  assign occ_last  = AW'(occ - CW'(1));
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign occ_wide  = {{COUNT_W{1'b0}}, occ};
  assign new_entry = '{value: req_q.item_value, prio: req_q.item_priority};
  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req.req_type == REQ_INSERT) begin
            if (is_full) state_next = ST_OUT;
            else if (is_empty) state_next = ST_INS_WR;
            else state_next = ST_INS_CMP;
          end else begin
            if (is_empty) state_next = ST_OUT;
            else state_next = ST_EXT_SH;
          end
        end
      end
      ST_INS_CMP: begin
        if (!ins_shift) state_next = ST_OUT;
        else if (idx == '0) state_next = ST_INS_WR;
      end
      ST_INS_WR: state_next = ST_OUT;
      ST_EXT_SH: begin
        if (!more) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (rsp_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_next       = idx;
    occ_next       = occ;
    req_q_next     = req_q;
    res_next       = res;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && !rsp_ready;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = '0;
    ram_wr_data    = new_entry;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          req_q_next            = req;
          res_next.out_value    = '0;
          res_next.out_priority = '0;
          res_next.out_valid    = 1'b0;
          res_next.status       = STATUS_OK;
          res_next.entry_count  = '0;
          if (req.req_type == REQ_INSERT) begin
            if (is_full) begin
              res_next.status = STATUS_FULL;
            end else if (!is_empty) begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = occ_last;
              idx_next    = occ_last;
            end
          end else begin
            if (is_empty) begin
              res_next.status = STATUS_EMPTY;
            end else begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = '0;
              idx_next    = '0;
            end
          end
        end
      end
      ST_INS_CMP: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx_up;
        if (ins_shift) begin
          ram_wr_data = rd_entry;
          if (idx != '0) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_dn;
            idx_next    = idx_dn;
          end
        end else begin
          ram_wr_data = new_entry;
          occ_next    = occ + CW'(1);
        end
      end
      ST_INS_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = '0;
        ram_wr_data = new_entry;
        occ_next    = occ + CW'(1);
      end
      ST_EXT_SH: begin
        if (idx == '0) begin
          res_next.out_value    = rd_entry.value;
          res_next.out_priority = rd_entry.prio;
          res_next.out_valid    = 1'b1;
        end else begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = idx_dn;
          ram_wr_data = rd_entry;
        end
        if (more) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = idx_up;
          idx_next    = idx_up;
        end else begin
          occ_next = occ - CW'(1);
        end
      end
      ST_OUT: begin
        if (rsp_free) begin
          rsp_valid_next       = 1'b1;
          rsp_next             = res;
          rsp_next.entry_count = occ_wide[COUNT_W-1:0];
        end
      end
      default: begin
        idx_next = idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occ       <= occ_next;
      rsp_valid <= rsp_valid_next;
    end
    idx   <= idx_next;
    req_q <= req_q_next;
    res   <= res_next;
    rsp   <= rsp_next;
  end

endmodule

// ===== hw/rtl/spq_checker.sv =====
// port level checks for the sorted priority queue, bound to the top level
`timescale 1ns / 1ps
`include "sorted_priority_queue_assert.svh"

module spq_checker
  import spq_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  logic unused_req;
  assign unused_req = req_valid ^ (^req);

  `SPQ_ASSERT_RST(a_reset_idle, rst |=> req_ready && !rsp_valid, "not idle after reset")

  `SPQ_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "result moved while stalled")

  `SPQ_ASSERT(a_empty_count, rsp_valid && rsp.status == STATUS_EMPTY |-> rsp.entry_count == '0 && !rsp.out_valid, "empty extract with entries")

  `SPQ_ASSERT(a_no_entry_zero, rsp_valid && !rsp.out_valid |-> rsp.out_value == '0 && rsp.out_priority == '0, "payload without extracted entry")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// ===== test/sorted_priority_queue_checker.sv =====
// checker for the sorted priority queue: predicts every result beat and compares it
`timescale 1ns / 1ps

module sorted_priority_queue_checker
  import spq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   errors,
  output int   pending,
  output int   n_stored,
  output int   n_dropped_full,
  output int   n_extracted,
  output int   n_empty_extract,
  output int   peak_fill
);

  entry_t            slots [CAPACITY_DEF];
  logic [COUNT_W-1:0] fill;
  rsp_t              awaited_results [$];
  rsp_t              want;
  rsp_t              outcome;

  initial begin
    errors          = 0;
    pending         = 0;
    n_stored        = 0;
    n_dropped_full  = 0;
    n_extracted     = 0;
    n_empty_extract = 0;
    peak_fill       = 0;
    fill            = '0;
  end

  function automatic rsp_t queue_outcome(req_t r);
    rsp_t res;
    int   i;
    int   pos;
    res        = '0;
    res.status = STATUS_OK;
    if (r.req_type == REQ_EXTRACT) begin
      if (fill == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.out_value    = slots[0].value;
        res.out_priority = slots[0].prio;
        res.out_valid    = 1'b1;
        for (i = 1; i < fill; i++) slots[i-1] = slots[i];
        fill = fill - 1'b1;
      end
    end else if (fill >= CAPACITY_DEF) begin
      res.status = STATUS_FULL;
    end else begin
      // new entry goes ahead of the first entry with equal or larger priority
      pos = int'(fill);
      for (i = 0; i < fill; i++) begin
        if (slots[i].prio >= r.item_priority) begin
          pos = i;
          break;
        end
      end
      for (i = int'(fill); i > pos; i--) slots[i] = slots[i-1];
      slots[pos].value = r.item_value;
      slots[pos].prio  = r.item_priority;
      fill = fill + 1'b1;
    end
    res.entry_count = fill;
    return res;
  endfunction

  task automatic compare_field(input string field, input logic signed [63:0] want_v,
                               input logic signed [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s expected %0d got %0d", field, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill = '0;
      awaited_results.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with nothing awaited");
          errors++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("out_value", 64'(want.out_value), 64'(rsp.out_value));
          compare_field("out_priority", 64'(want.out_priority), 64'(rsp.out_priority));
          compare_field("out_valid", 64'(want.out_valid), 64'(rsp.out_valid));
          compare_field("status", 64'(want.status), 64'(rsp.status));
          compare_field("entry_count", 64'(want.entry_count), 64'(rsp.entry_count));
        end
      end
      if (req_valid && req_ready) begin
        outcome = queue_outcome(req);
        awaited_results.push_back(outcome);
        case (outcome.status)
          STATUS_FULL:  n_dropped_full++;
          STATUS_EMPTY: n_empty_extract++;
          default: begin
            if (outcome.out_valid) n_extracted++;
            else n_stored++;
          end
        endcase
        if (int'(fill) > peak_fill) peak_fill = int'(fill);
      end
    end
    pending = awaited_results.size();
  end

endmodule

// ===== test/sorted_priority_queue_tb.sv =====
// testbench top for the sorted priority queue: stimulus, handshake idling and verdict
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 460;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int chk_errors;
  int pending;
  int n_stored;
  int n_dropped_full;
  int n_extracted;
  int n_empty_extract;
  int peak_fill;

  int send_idle   = 32;
  int recv_idle   = 71;
  int hold_asked  = 0;
  int hold_served = 0;
  int quiet_cycles = 0;
  int n_sent      = 0;

  sorted_priority_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  sorted_priority_queue_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .req             (req),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .rsp             (rsp),
    .errors          (chk_errors),
    .pending         (pending),
    .n_stored        (n_stored),
    .n_dropped_full  (n_dropped_full),
    .n_extracted     (n_extracted),
    .n_empty_extract (n_empty_extract),
    .peak_fill       (peak_fill)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls, plus a long hold-off when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_asked != hold_served) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_served++;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic req_t insert_beat(logic signed [VAL_W-1:0] v, logic [PRI_W-1:0] p);
    req_t r;
    r.req_type      = REQ_INSERT;
    r.item_value    = v;
    r.item_priority = p;
    return r;
  endfunction

  function automatic req_t extract_beat();
    req_t r;
    r.req_type      = REQ_EXTRACT;
    r.item_value    = $urandom;
    r.item_priority = PRI_W'($urandom);
    return r;
  endfunction

  function automatic logic [PRI_W-1:0] pick_priority();
    int k;
    k = $urandom_range(9);
    if (k < 5) return PRI_W'($urandom_range(7));
    if (k < 7) return PRI_W'($urandom);
    if (k == 7) return '0;
    if (k == 8) return '1;
    return PRI_W'($urandom_range(16'hffff, 16'hfff0));
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int k;
    k = $urandom_range(11);
    case (k)
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // starts at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_beat(req_t r);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    n_sent++;
    @(negedge clk);
  endtask

  initial begin
    int i;
    int phase;
    int n;
    int insert_bias;
    logic [PRI_W-1:0] p;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty extract, fill with extremes and ties, full insert, a few extracts
    send_beat(extract_beat());
    for (i = 0; i < CAPACITY_DEF; i++) begin
      case (i % 4)
        0:       p = 16'hffff;
        2:       p = 16'h8000;
        default: p = 16'h0000;
      endcase
      case (i % 3)
        0:       send_beat(insert_beat(32'sh7fffffff, p));
        1:       send_beat(insert_beat(32'sh80000000, p));
        default: send_beat(insert_beat(i, p));
      endcase
    end
    send_beat(insert_beat(-1, 16'h0001));
    repeat (4) send_beat(extract_beat());
    send_beat(insert_beat(-2, 16'h0000));
    send_beat(extract_beat());

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 32;
          recv_idle = 71;
        end
        1: begin
          send_idle = 71;
          recv_idle = 32;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      insert_bias = 50;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // insert bias drifts so the queue swings between empty and full
        if (n % 40 == 0) begin
          case ($urandom_range(2))
            0:       insert_bias = 15;
            1:       insert_bias = 50;
            default: insert_bias = 85;
          endcase
        end
        if (phase == 2 && n == 100) hold_asked++;
        if ($urandom_range(99) < insert_bias) send_beat(insert_beat(pick_value(), pick_priority()));
        else send_beat(extract_beat());
      end
    end

    req_valid <= 1'b0;
    recv_idle = 0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("sent %0d request beats: %0d stored, %0d dropped on full, %0d extracted,",
             n_sent, n_stored, n_dropped_full, n_extracted);
    $display("%0d extracts on empty, peak fill %0d of %0d", n_empty_extract, peak_fill,
             CAPACITY_DEF);
    if (pending != 0) $error("%0d results never arrived", pending);
    if (chk_errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
